FILE: src/deq_pkg.sv
// Shared types and codes for the double-ended queue.
package deq_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int FUNC_WIDTH  = 3;
   localparam int COUNT_WIDTH = 11;

   localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_PUSH_BACK  = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_POP_BACK   = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_CLEAR      = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_MEM,
      SRC_PUSH
   } word_src_type;

   typedef enum logic [1:0] {
      POP_NONE,
      POP_FRONT,
      POP_BACK
   } pop_src_type;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0]        func;
      logic signed [WORD_WIDTH-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] popped_value;
      logic [1:0]                   status;
      logic [COUNT_WIDTH-1:0]       count;
      logic signed [WORD_WIDTH-1:0] front_value;
      logic signed [WORD_WIDTH-1:0] back_value;
   } rsp_type;

   typedef struct packed {
      logic                         valid;
      logic [1:0]                   status;
      logic [COUNT_WIDTH-1:0]       count;
      word_src_type                 front_src;
      word_src_type                 back_src;
      pop_src_type                  pop_src;
      logic signed [WORD_WIDTH-1:0] push_value;
   } deq_stage_type;

endpackage

FILE: src/double_ended_queue.sv
// Double-ended queue top level: input register, pointer stage, store and result stage.
// A transaction passes the input register, the pointer stage and the result
// register in turn, then is on rsp_data for one cycle.
// Throughput: one transaction per cycle; busy stays low, the word store serves one
// write and two reads every cycle.
// Reset: synchronous; empties the queue (head, tail, count to zero) and drops
// transactions in flight. Results are strobed once and cannot be stalled.
module double_ended_queue import deq_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);

   req_type               req_ff;
   logic                  req_valid_ff;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [WORD_WIDTH-1:0] wr_data;
   logic [IDX_W-1:0]      rd_addr_a;
   logic [IDX_W-1:0]      rd_addr_b;
   logic [WORD_WIDTH-1:0] rd_data_a;
   logic [WORD_WIDTH-1:0] rd_data_b;
   deq_stage_type         stage;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      req_ff <= req_data;
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
   end

   deq_ptr #(
      .CAPACITY (CAPACITY)
   ) u_ptr (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (req_valid_ff),
      .op        (req_ff),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .stage     (stage)
   );

   deq_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   deq_out u_out (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .rd_data_a  (rd_data_a),
      .rd_data_b  (rd_data_b),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: src/deq_ram.sv
// Generic RAM with one write port and two registered read ports.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: src/deq_ptr.sv
// Head, tail and count update, store write and read addressing.
module deq_ptr import deq_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        op_valid,
   input  req_type                     op,
   output logic                        wr_en,
   output logic [$clog2(CAPACITY)-1:0] wr_addr,
   output logic [WORD_WIDTH-1:0]       wr_data,
   output logic [$clog2(CAPACITY)-1:0] rd_addr_a,
   output logic [$clog2(CAPACITY)-1:0] rd_addr_b,
   output deq_stage_type               stage
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_dec, head_inc, tail_dec, tail_inc;
   logic             empty, full;
   deq_stage_type    stage_ff, stage_in;

   always_comb begin
      head_dec = (head_ff == '0) ? LAST_IDX : head_ff - IDX_W'(1);
      head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + IDX_W'(1);
      tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - IDX_W'(1);
      tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + IDX_W'(1);
      empty    = (count_ff == '0);
      full     = (count_ff == FULL_CNT);

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_ff;
      wr_data  = op.push_value;
      stage_in = '0;
      stage_in.valid      = op_valid;
      stage_in.status     = STATUS_OK;
      stage_in.pop_src    = POP_NONE;
      stage_in.push_value = op.push_value;

      if (op_valid) begin
         unique case (op.func)
            FUNC_PUSH_FRONT: begin
               if (full) begin
                  stage_in.status = STATUS_FULL;
               end else begin
                  head_in  = head_dec;
                  wr_en    = 1'b1;
                  wr_addr  = head_dec;
                  count_in = count_ff + ONE_CNT;
               end
            end
            FUNC_PUSH_BACK: begin
               if (full) begin
                  stage_in.status = STATUS_FULL;
               end else begin
                  tail_in  = tail_inc;
                  wr_en    = 1'b1;
                  wr_addr  = tail_ff;
                  count_in = count_ff + ONE_CNT;
               end
            end
            FUNC_POP_FRONT: begin
               if (empty) begin
                  stage_in.status = STATUS_EMPTY;
               end else begin
                  head_in          = head_inc;
                  count_in         = count_ff - ONE_CNT;
                  stage_in.pop_src = POP_FRONT;
               end
            end
            FUNC_POP_BACK: begin
               if (empty) begin
                  stage_in.status = STATUS_EMPTY;
               end else begin
                  tail_in          = tail_dec;
                  count_in         = count_ff - ONE_CNT;
                  stage_in.pop_src = POP_BACK;
               end
            end
            FUNC_CLEAR: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end

      rd_addr_a = head_in;
      rd_addr_b = (tail_in == '0) ? LAST_IDX : tail_in - IDX_W'(1);

      stage_in.count = COUNT_WIDTH'(count_in);

      if (count_in == '0) begin
         stage_in.front_src = SRC_ZERO;
      end else if (wr_en && (op.func == FUNC_PUSH_FRONT || count_in == ONE_CNT)) begin
         stage_in.front_src = SRC_PUSH;
      end else begin
         stage_in.front_src = SRC_MEM;
      end

      if (count_in == '0) begin
         stage_in.back_src = SRC_ZERO;
      end else if (wr_en && (op.func == FUNC_PUSH_BACK || count_in == ONE_CNT)) begin
         stage_in.back_src = SRC_PUSH;
      end else begin
         stage_in.back_src = SRC_MEM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

FILE: src/deq_out.sv
// End word selection, popped word tracking and the result register.
module deq_out import deq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  deq_stage_type         stage,
   input  logic [WORD_WIDTH-1:0] rd_data_a,
   input  logic [WORD_WIDTH-1:0] rd_data_b,
   output logic                  rsp_strobe,
   output rsp_type               rsp_data
);

   logic [WORD_WIDTH-1:0] front_ff, front_in;
   logic [WORD_WIDTH-1:0] back_ff, back_in;
   logic [WORD_WIDTH-1:0] popped;
   rsp_type               rsp_ff, rsp_in;
   logic                  strobe_ff;

   always_comb begin
      unique case (stage.front_src)
         SRC_MEM:  front_in = rd_data_a;
         SRC_PUSH: front_in = stage.push_value;
         default:  front_in = '0;
      endcase

      unique case (stage.back_src)
         SRC_MEM:  back_in = rd_data_b;
         SRC_PUSH: back_in = stage.push_value;
         default:  back_in = '0;
      endcase

      unique case (stage.pop_src)
         POP_FRONT: popped = front_ff;
         POP_BACK:  popped = back_ff;
         default:   popped = '0;
      endcase

      rsp_in.popped_value = popped;
      rsp_in.status       = stage.status;
      rsp_in.count        = stage.count;
      rsp_in.front_value  = front_in;
      rsp_in.back_value   = back_in;
   end

   always_ff @(posedge clock) begin
      if (stage.valid) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         rsp_ff   <= rsp_in;
      end
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= stage.valid;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
